/* hdl/masked_sprite_blitter_1bpp_assert.svh */
// Assertion macros shared by the sprite blitter RTL.
`ifndef MASKED_SPRITE_BLITTER_1BPP_ASSERT_SVH
`define MASKED_SPRITE_BLITTER_1BPP_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define MSB1_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sprite blitter: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define MSB1_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sprite blitter: next-cycle check failed");
`else
`define MSB1_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define MSB1_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* hdl/msb1_pkg.sv */
// Package with the sizes, codes and transaction types of the sprite blitter.
package msb1_pkg;
	localparam int SPRITE_ROWS  = 16;
	localparam int FB_ROW_WORDS = 16;
	localparam int FB_WORDS     = 4096;
	localparam int SPRITE_SLOTS = 16;

	localparam int SPRITE_COLS  = 4;
	localparam int SPRITE_WORDS = SPRITE_ROWS * SPRITE_COLS;
	localparam int STORE_WORDS  = SPRITE_SLOTS * SPRITE_WORDS;
	localparam int WORD_W       = 16;

	localparam int SA_W  = $clog2(STORE_WORDS);
	localparam int FA_W  = $clog2(FB_WORDS);
	localparam int R_W   = $clog2(SPRITE_ROWS);
	localparam int J_W   = $clog2(SPRITE_COLS);
	localparam int COL_W = $clog2(256 / WORD_W + SPRITE_COLS + 1);
	localparam int LIN_W = $clog2((256 + SPRITE_ROWS) * FB_ROW_WORDS + 256 / WORD_W
		+ SPRITE_COLS + 1);

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_DRAW  = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  sprite_index;
		logic [5:0]  word_index;
		logic [15:0] color_word;
		logic [15:0] alpha_word;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic        background;
		logic [11:0] fb_address;
	} cmd_t;

	typedef struct packed {
		logic [15:0] read_word;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic [3:0] shift;
		logic       second;
	} blend_ctrl_t;
endpackage

/* hdl/msb1_ram.sv */
// Generic single-port RAM with registered read data.
module msb1_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* hdl/msb1_blend.sv */
// Shared shift and masked blend unit of the sprite blitter.
module msb1_blend (
	input  msb1_pkg::blend_ctrl_t ctrl,
	input  logic [15:0]           color_in,
	input  logic [15:0]           alpha_in,
	input  logic [15:0]           old_word,
	output logic [15:0]           new_word
);
	import msb1_pkg::*;

	logic [2*WORD_W-1:0] color_wide;
	logic [2*WORD_W-1:0] alpha_wide;
	logic [WORD_W-1:0]   color_sh;
	logic [WORD_W-1:0]   alpha_sh;

	// One right shift of the word padded with zeros serves both passes: the upper
	// half is the first pass, the lower half holds the bits that spill over.
	assign color_wide = {color_in, {WORD_W{1'b0}}} >> ctrl.shift;
	assign alpha_wide = {alpha_in, {WORD_W{1'b0}}} >> ctrl.shift;
	assign color_sh   = ctrl.second ? color_wide[WORD_W-1:0] : color_wide[2*WORD_W-1:WORD_W];
	assign alpha_sh   = ctrl.second ? alpha_wide[WORD_W-1:0] : alpha_wide[2*WORD_W-1:WORD_W];
	assign new_word   = (color_sh & alpha_sh) | (old_word & ~alpha_sh);
endmodule

/* hdl/masked_sprite_blitter_1bpp.sv */
// Top level of the one-bit-per-pixel masked sprite blitter.
// A command transaction is accepted at a rising edge where start is high and busy
// is low. Each command produces exactly one result transaction: done is high for
// one cycle and result holds read_word and status during that cycle. The receiver
// cannot stall, so the result must be taken in that cycle.
// What each command does between acceptance and the strobe:
//   load  - one write into the sprite store,
//   read  - registered read of the framebuffer memory,
//   clear - one framebuffer word written per cycle across the whole framebuffer,
//   draw  - each blended word is read and then written through the single
//           framebuffer port and the shared blend unit; a second, spill pass
//           per row runs only when pos_x is not a multiple of 16.
// Busy stays high from acceptance until the strobe, though a load never raises
// it, so one command runs at a time.
// Reset clears the sequencer and the strobe; the sprite store and framebuffer keep
// no reset and hold undefined data until written.
module masked_sprite_blitter_1bpp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  msb1_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output msb1_pkg::rsp_t result
);
	import msb1_pkg::*;

	`include "masked_sprite_blitter_1bpp_assert.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_DRD   = 3'd2;
	localparam logic [2:0] ST_DWR   = 3'd3;
	localparam logic [2:0] ST_RWAIT = 3'd4;

	logic [2:0]       state_q;
	logic             done_q;
	logic             drop_q;
	logic [FA_W-1:0]  cnt_q;
	logic [R_W-1:0]   r_q;
	logic [J_W-1:0]   j_q;
	logic             pass_q;
	logic [LIN_W-1:0] rowbase_q;
	logic [3:0]       slot_q;
	logic [3:0]       shift_q;
	logic [3:0]       col0_q;
	logic             bg_q;
	logic [11:0]      cmd_fba_q;
	rsp_t             result_q;

	logic             accept;
	logic             load_ok;
	logic [SA_W-1:0]  load_addr;
	logic [SA_W-1:0]  draw_addr;
	logic [COL_W-1:0] col;
	logic [LIN_W-1:0] lin_addr;
	logic             in_range;
	logic             last_word;
	logic             last_row;

	logic             sp_we;
	logic [SA_W-1:0]  sp_addr;
	logic [31:0]      sp_rdata;
	logic             fb_we;
	logic [FA_W-1:0]  fb_addr;
	logic [WORD_W-1:0] fb_wdata;
	logic [WORD_W-1:0] fb_rdata;
	logic [WORD_W-1:0] blend_out;
	blend_ctrl_t      bctrl;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// A load outside the slot range or the sprite size is silently ignored.
	assign load_ok   = (32'(cmd.sprite_index) < SPRITE_SLOTS)
		&& (32'(cmd.word_index) < SPRITE_WORDS);
	assign load_addr = SA_W'(cmd.sprite_index) * SA_W'(SPRITE_WORDS) + SA_W'(cmd.word_index);
	assign draw_addr = SA_W'(slot_q) * SA_W'(SPRITE_WORDS) + SA_W'(r_q) * SA_W'(SPRITE_COLS)
		+ SA_W'(j_q);

	// The second pass lands one word column to the right of the first.
	assign col       = COL_W'(col0_q) + COL_W'(j_q) + COL_W'(pass_q);
	assign lin_addr  = rowbase_q + LIN_W'(col);
	assign in_range  = (32'(col) < FB_ROW_WORDS) && (32'(lin_addr) < FB_WORDS);
	assign last_word = (j_q == J_W'(SPRITE_COLS - 1));
	assign last_row  = (r_q == R_W'(SPRITE_ROWS - 1));

	assign bctrl.shift  = shift_q;
	assign bctrl.second = pass_q;

	// Sprite store port: loads while idle, draw reads otherwise.
	always_comb begin
		sp_we   = 1'b0;
		sp_addr = draw_addr;
		if (state_q == ST_IDLE) begin
			sp_addr = load_addr;
			sp_we   = accept && (cmd.func == FUNC_LOAD) && load_ok;
		end
	end

	// Framebuffer port: shared by clear, draw and read.
	always_comb begin
		fb_we    = 1'b0;
		fb_addr  = lin_addr[FA_W-1:0];
		fb_wdata = blend_out;
		case (state_q)
			ST_IDLE: begin
				fb_addr = FA_W'(cmd.fb_address);
			end
			ST_CLEAR: begin
				fb_we    = 1'b1;
				fb_addr  = cnt_q;
				fb_wdata = bg_q ? {WORD_W{1'b1}} : {WORD_W{1'b0}};
			end
			ST_DWR: begin
				fb_we = in_range;
			end
			default: begin
				fb_we = 1'b0;
			end
		endcase
	end

	msb1_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_sprite_ram (
		.clk   (clk),
		.we    (sp_we),
		.addr  (sp_addr),
		.wdata ({cmd.color_word, cmd.alpha_word}),
		.rdata (sp_rdata)
	);

	msb1_ram #(.WIDTH(WORD_W), .DEPTH(FB_WORDS)) u_frame_ram (
		.clk   (clk),
		.we    (fb_we),
		.addr  (fb_addr),
		.wdata (fb_wdata),
		.rdata (fb_rdata)
	);

	msb1_blend u_blend (
		.ctrl     (bctrl),
		.color_in (sp_rdata[31:16]),
		.alpha_in (sp_rdata[15:0]),
		.old_word (fb_rdata),
		.new_word (blend_out)
	);

	// Sequencer: control state with asynchronous reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			drop_q  <= 1'b0;
			cnt_q   <= '0;
			r_q     <= '0;
			j_q     <= '0;
			pass_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						drop_q <= 1'b0;
						cnt_q  <= '0;
						r_q    <= '0;
						j_q    <= '0;
						pass_q <= 1'b0;
						case (cmd.func)
							FUNC_LOAD: begin
								done_q <= 1'b1;
							end
							FUNC_CLEAR: begin
								state_q <= ST_CLEAR;
							end
							FUNC_DRAW: begin
								if (32'(cmd.sprite_index) < SPRITE_SLOTS) begin
									state_q <= ST_DRD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								state_q <= ST_RWAIT;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == FA_W'(FB_WORDS - 1)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_DRD: begin
					state_q <= ST_DWR;
				end
				ST_DWR: begin
					if (!in_range) begin
						drop_q <= 1'b1;
					end
					state_q <= ST_DRD;
					j_q     <= j_q + 1'b1;
					if (last_word) begin
						j_q <= '0;
						if (!pass_q && (shift_q != 4'd0)) begin
							pass_q <= 1'b1;
						end else begin
							pass_q <= 1'b0;
							r_q    <= r_q + 1'b1;
							if (last_row) begin
								state_q <= ST_IDLE;
								done_q  <= 1'b1;
							end
						end
					end
				end
				ST_RWAIT: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command fields and result payload, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q    <= cmd.sprite_index;
			shift_q   <= cmd.pos_x[3:0];
			col0_q    <= cmd.pos_x[7:4];
			bg_q      <= cmd.background;
			rowbase_q <= LIN_W'(cmd.pos_y) * LIN_W'(FB_ROW_WORDS);
			result_q  <= '0;
		end
		if (state_q == ST_DWR && last_word && !(!pass_q && (shift_q != 4'd0))) begin
			rowbase_q <= rowbase_q + LIN_W'(FB_ROW_WORDS);
		end
		if (state_q == ST_DWR && last_word && last_row
			&& !(!pass_q && (shift_q != 4'd0))) begin
			result_q.status <= drop_q || !in_range;
		end
		if (state_q == ST_RWAIT) begin
			result_q.read_word <= (32'(cmd_fba_q) < FB_WORDS) ? fb_rdata : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_fba_q <= cmd.fb_address;
		end
	end

	// The strobe only ever appears with the sequencer back at rest.
	`MSB1_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	// A load transaction completes in the following cycle.
	`MSB1_ASSERT_NEXT(a_load_one, clk, arst_n, accept && (cmd.func == FUNC_LOAD), done)
	// Every framebuffer read of a draw is followed by its write cycle.
	`MSB1_ASSERT_NEXT(a_draw_rmw, clk, arst_n, state_q == ST_DRD, state_q == ST_DWR)
	// A write to the framebuffer only happens in a clear or in the write cycle of a draw.
	`MSB1_ASSERT_SAME(a_fb_we_src, clk, arst_n, fb_we,
		(state_q == ST_CLEAR) || (state_q == ST_DWR))
endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the one-bit-per-pixel masked sprite blitter.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import msb1_pkg::*;

	// Stimulus stops once this many command transactions have been accepted.
	localparam int ITEM_TARGET = 1700;
	// After the last result, wait out the longest command (a clear) to catch
	// any stray strobe.
	localparam int DRAIN_CYCLES = FB_WORDS + 100;
	// Only the first mismatches are printed; all of them are counted.
	localparam int PRINT_LIMIT = 100;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	rsp_t result;

	masked_sprite_blitter_1bpp dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mirror of the block's storage. The sprite store and framebuffer mirrors
	// are updated in the order commands are accepted, which is also the order
	// the block executes them, since only one command runs at a time.
	logic [15:0] mirror_color [STORE_WORDS];
	logic [15:0] mirror_alpha [STORE_WORDS];
	logic [15:0] mirror_frame [FB_WORDS];

	// Track which sprite words have been written. A draw touches all words of
	// its slot, so only slots whose every word has been loaded may be drawn.
	bit loaded_word [STORE_WORDS];
	int loaded_count [SPRITE_SLOTS];

	// Results owed by the block, oldest first.
	rsp_t issued_rsp_q[$];

	int mismatches;
	int results_seen;
	int items_sent;
	bit idle_on;
	bit quiet;

	// One row of the directed table: the command, and either a result typed in
	// by hand or a flag that the mirror supplies the expected result.
	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t want;
	} probe_t;

	probe_t probes[$];

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Blend one shifted colour/alpha pair into the framebuffer mirror. Writes
	// past the right edge of a row or past the end of the buffer are dropped
	// and reported back as clipped; they never wrap into the next row.
	function automatic bit merge_word(int row, int col, logic [15:0] cw, logic [15:0] aw);
		int addr;
		if (col >= FB_ROW_WORDS)
			return 1'b1;
		addr = row * FB_ROW_WORDS + col;
		if (addr >= FB_WORDS)
			return 1'b1;
		mirror_frame[addr] = (cw & aw) | (mirror_frame[addr] & ~aw);
		return 1'b0;
	endfunction

	// Apply one command to the mirror and return the result it should produce.
	function automatic rsp_t blit_effect(cmd_t c);
		rsp_t        outcome;
		int          base;
		int          col0;
		int          sh;
		int          a;
		bit          clipped;
		logic [15:0] cw;
		logic [15:0] aw;
		outcome = '0;
		clipped = 1'b0;
		case (c.func)
			FUNC_LOAD: begin
				if (int'(c.sprite_index) < SPRITE_SLOTS && int'(c.word_index) < SPRITE_WORDS) begin
					a = int'(c.sprite_index) * SPRITE_WORDS + int'(c.word_index);
					mirror_color[a] = c.color_word;
					mirror_alpha[a] = c.alpha_word;
					if (!loaded_word[a]) begin
						loaded_word[a] = 1'b1;
						loaded_count[c.sprite_index]++;
					end
				end
			end
			FUNC_CLEAR: begin
				foreach (mirror_frame[i])
					mirror_frame[i] = c.background ? 16'hFFFF : 16'h0000;
			end
			FUNC_DRAW: begin
				if (int'(c.sprite_index) < SPRITE_SLOTS) begin
					base = int'(c.sprite_index) * SPRITE_WORDS;
					col0 = int'(c.pos_x[7:4]);
					sh   = int'(c.pos_x[3:0]);
					for (int row = 0; row < SPRITE_ROWS; row++) begin
						// First pass: right-shifted words into their home columns.
						for (int j = 0; j < SPRITE_COLS; j++) begin
							a  = base + row * SPRITE_COLS + j;
							cw = mirror_color[a] >> sh;
							aw = mirror_alpha[a] >> sh;
							if (merge_word(int'(c.pos_y) + row, col0 + j, cw, aw))
								clipped = 1'b1;
						end
						// Second pass: the bits shifted out spill into the next column.
						if (sh != 0) begin
							for (int j = 0; j < SPRITE_COLS; j++) begin
								a  = base + row * SPRITE_COLS + j;
								cw = mirror_color[a] << (16 - sh);
								aw = mirror_alpha[a] << (16 - sh);
								if (merge_word(int'(c.pos_y) + row, col0 + j + 1, cw, aw))
									clipped = 1'b1;
							end
						end
					end
					outcome.status = clipped;
				end
			end
			FUNC_READ: begin
				if (int'(c.fb_address) < FB_WORDS)
					outcome.read_word = mirror_frame[c.fb_address];
			end
		endcase
		return outcome;
	endfunction

	function automatic cmd_t op_load(int slot, int widx, logic [15:0] colr, logic [15:0] alph);
		cmd_t c;
		c = '0;
		c.func         = FUNC_LOAD;
		c.sprite_index = 4'(slot);
		c.word_index   = 6'(widx);
		c.color_word   = colr;
		c.alpha_word   = alph;
		return c;
	endfunction

	function automatic cmd_t op_clear(bit bg);
		cmd_t c;
		c = '0;
		c.func       = FUNC_CLEAR;
		c.background = bg;
		return c;
	endfunction

	function automatic cmd_t op_draw(int slot, int x, int y);
		cmd_t c;
		c = '0;
		c.func         = FUNC_DRAW;
		c.sprite_index = 4'(slot);
		c.pos_x        = 8'(x);
		c.pos_y        = 8'(y);
		return c;
	endfunction

	function automatic cmd_t op_read(int addr);
		cmd_t c;
		c = '0;
		c.func       = FUNC_READ;
		c.fb_address = 12'(addr);
		return c;
	endfunction

	function automatic void row_known(cmd_t c, logic [15:0] rd, logic st);
		probe_t p;
		p.c              = c;
		p.typed          = 1'b1;
		p.want.read_word = rd;
		p.want.status    = st;
		probes.push_back(p);
	endfunction

	function automatic void row_predicted(cmd_t c);
		probe_t p;
		p.c     = c;
		p.typed = 1'b0;
		p.want  = '0;
		probes.push_back(p);
	endfunction

	// Every field starts random, so operand bits that a command does not use
	// still toggle; callers then overwrite the fields that matter.
	function automatic cmd_t random_cmd();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(cmd_t)-1:0];
	endfunction

	// Pick a slot whose every word has been loaded, so a draw never reads an
	// unwritten sprite word. Slots 0 and 15 are filled before anything else.
	function automatic logic [3:0] pick_full_slot();
		int full_slots[$];
		for (int s = 0; s < SPRITE_SLOTS; s++)
			if (loaded_count[s] == SPRITE_WORDS)
				full_slots.push_back(s);
		return 4'(full_slots[$urandom_range(0, full_slots.size() - 1)]);
	endfunction

	// Drive one command transaction and hold it until the block takes it.
	// Called right after a rising edge. The command is accepted at the first
	// edge where start is high and busy is low; the expected result is queued
	// once busy reads low after an edge. An idle burst may follow, lowering start.
	task automatic issue_cmd(input cmd_t c, input bit typed, input rsp_t want);
		rsp_t mirrored;
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		mirrored = blit_effect(c);
		issued_rsp_q.push_back(typed ? want : mirrored);
		items_sent++;
		if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// Load every word of one slot with random content. About a quarter of the
	// words are fully opaque, the rest carry random masks.
	task automatic fill_slot(input int slot);
		cmd_t c;
		for (int w = 0; w < SPRITE_WORDS; w++) begin
			c              = random_cmd();
			c.func         = FUNC_LOAD;
			c.sprite_index = 4'(slot);
			c.word_index   = 6'(w);
			if ($urandom_range(0, 3) == 0)
				c.alpha_word = 16'hFFFF;
			issue_cmd(c, 1'b0, '0);
		end
	endtask

	// Result checker. The receiver cannot stall, so every strobe is taken at
	// the edge that ends its cycle and compared with the oldest expectation.
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (issued_rsp_q.size() == 0) begin
				flag_mismatch($sformatf("result %0d arrived with no command outstanding",
					results_seen));
			end else begin
				want = issued_rsp_q.pop_front();
				if (result.read_word !== want.read_word)
					flag_mismatch($sformatf("result %0d read_word got %h want %h",
						results_seen, result.read_word, want.read_word));
				if (result.status !== want.status)
					flag_mismatch($sformatf("result %0d status got %b want %b",
						results_seen, result.status, want.status));
			end
		end
	end

	initial begin
		cmd_t c;
		int   pick;
		int   last_x;
		int   last_y;
		int   row;
		int   col;

		mismatches   = 0;
		results_seen = 0;
		items_sent   = 0;
		idle_on      = 1'b1;
		quiet        = 1'b0;
		last_x       = 0;
		last_y       = 0;
		foreach (mirror_color[i]) begin
			mirror_color[i] = '0;
			mirror_alpha[i] = '0;
			loaded_word[i]  = 1'b0;
		end
		foreach (mirror_frame[i])
			mirror_frame[i] = '0;
		foreach (loaded_count[i])
			loaded_count[i] = 0;

		// Directed table. The first command is a clear, so every framebuffer
		// word is defined before any read or draw touches it. Rows with a
		// typed result are those whose answer is plain: loads and clears give
		// zeros, reads right after a clear give the fill value, and draws at the
		// right or bottom edge report whether they clip.
		row_known(op_clear(1'b0), 16'h0000, 1'b0);
		row_known(op_read(0), 16'h0000, 1'b0);
		row_known(op_read(FB_WORDS - 1), 16'h0000, 1'b0);
		row_known(op_clear(1'b1), 16'h0000, 1'b0);
		row_known(op_read(2047), 16'hFFFF, 1'b0);
		row_known(op_load(15, 63, 16'hFFFF, 16'hFFFF), 16'h0000, 1'b0);
		row_known(op_load(0, 0, 16'h0000, 16'hFFFF), 16'h0000, 1'b0);
		row_known(op_load(0, 1, 16'hFFFF, 16'h0000), 16'h0000, 1'b0);
		// Aligned draw at the origin: a single pass per row.
		row_predicted(op_draw(0, 0, 0));
		row_predicted(op_read(0));
		row_predicted(op_read(1));
		// Unaligned draw: the spill pass into the following column runs.
		row_predicted(op_draw(0, 8, 100));
		row_predicted(op_read(100 * FB_ROW_WORDS));
		row_predicted(op_read(100 * FB_ROW_WORDS + 4));
		// Bottom-right corner: only one word lands, the rest is clipped.
		row_known(op_draw(15, 255, 255), 16'h0000, 1'b1);
		row_predicted(op_read(FB_WORDS - 1));
		// An aligned sprite that exactly fills the bottom-right corner.
		row_known(op_draw(0, 192, 240), 16'h0000, 1'b0);
		// One pixel further right, the spill column falls off the row.
		row_known(op_draw(0, 193, 240), 16'h0000, 1'b1);
		// One row lower, at the left edge, the last sprite row falls off the buffer.
		row_known(op_draw(0, 0, 241), 16'h0000, 1'b1);
		row_known(op_draw(15, 240, 0), 16'h0000, 1'b1);
		row_predicted(op_read(255 * FB_ROW_WORDS + 15));
		row_known(op_clear(1'b0), 16'h0000, 1'b0);
		row_predicted(op_draw(15, 15, 17));
		row_predicted(op_read(17 * FB_ROW_WORDS));
		row_predicted(op_read(17 * FB_ROW_WORDS + 4));

		// Every input is known from time zero; reset is held low and then released.
		arst_n <= 1'b0;
		start  <= 1'b0;
		cmd    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed draws need complete sprites in slots 0 and 15.
		fill_slot(0);
		fill_slot(15);

		foreach (probes[i])
			issue_cmd(probes[i].c, probes[i].typed, probes[i].want);

		// Random traffic. Draws and reads dominate; whole-slot fills are the
		// well-formed sequences that make more sprites drawable, single loads
		// rewrite words at random, and clears are rare because they are slow.
		// The last tenth of the run carries no idle bursts.
		while (items_sent < ITEM_TARGET) begin
			quiet = items_sent >= ITEM_TARGET * 9 / 10;
			if ($urandom_range(0, 39) == 0)
				idle_on = $urandom_range(0, 2) != 0;
			pick = $urandom_range(0, 99);
			c    = random_cmd();
			if (pick < 2) begin
				fill_slot($urandom_range(0, SPRITE_SLOTS - 1));
			end else if (pick < 5) begin
				c.func = FUNC_CLEAR;
				issue_cmd(c, 1'b0, '0);
			end else if (pick < 25) begin
				c.func = FUNC_LOAD;
				case ($urandom_range(0, 3))
					0: c.alpha_word = 16'hFFFF;
					1: c.alpha_word = 16'h0000;
					default: ;
				endcase
				if ($urandom_range(0, 7) == 0)
					c.color_word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				issue_cmd(c, 1'b0, '0);
			end else if (pick < 60) begin
				c.func         = FUNC_DRAW;
				c.sprite_index = pick_full_slot();
				// A quarter of the draws are word aligned and skip the spill
				// pass; half stay clear of the bottom edge.
				if ($urandom_range(0, 3) == 0)
					c.pos_x[3:0] = 4'h0;
				if ($urandom_range(0, 1) == 0)
					c.pos_y = 8'($urandom_range(0, 256 - SPRITE_ROWS));
				last_x = int'(c.pos_x);
				last_y = int'(c.pos_y);
				issue_cmd(c, 1'b0, '0);
			end else begin
				c.func = FUNC_READ;
				// Half the reads land on or next to the most recent draw.
				if ($urandom_range(0, 1) == 0) begin
					row          = last_y + $urandom_range(0, SPRITE_ROWS - 1);
					col          = last_x / 16 + $urandom_range(0, SPRITE_COLS);
					c.fb_address = 12'(row * FB_ROW_WORDS + col);
				end
				issue_cmd(c, 1'b0, '0);
			end
		end

		if (start)
			start <= 1'b0;
		while (issued_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("masked_sprite_blitter_1bpp verification clean");
		else
			$display("masked_sprite_blitter_1bpp verification failed");
		$finish;
	end

	// Watchdog. The slowest legal run is every command a clear plus the longest
	// idle burst, which stays near 70 ms; this allows several times that.
	initial begin
		#400ms;
		$display("masked_sprite_blitter_1bpp verification failed");
		$finish;
	end

endmodule
